// File: sv/bcrf_pkg.sv
package bcrf_pkg;

    // Access kinds carried on the input tuser
    localparam logic [2:0] KIND_RD_REG    = 3'd0;
    localparam logic [2:0] KIND_WR_REG    = 3'd1;
    localparam logic [2:0] KIND_RD_FLAGS  = 3'd2;
    localparam logic [2:0] KIND_WR_FLAGS  = 3'd3;
    localparam logic [2:0] KIND_RD_STATUS = 3'd4;
    localparam logic [2:0] KIND_WR_STATUS = 3'd5;
    localparam logic [2:0] KIND_RD_PC     = 3'd6;
    localparam logic [2:0] KIND_WR_PC     = 3'd7;

    // Register access widths
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    // Upper nibble of the register code for the banked and index ranges
    localparam logic [3:0] CODE_PREV_BANK = 4'hD;
    localparam logic [3:0] CODE_CUR_BANK  = 4'hE;
    localparam logic [3:0] CODE_INDEX     = 4'hF;

    localparam int unsigned NUM_BANKS    = 4;
    localparam int unsigned REGS_PER_BANK = 4;
    localparam int unsigned NUM_BANK_REGS = NUM_BANKS * REGS_PER_BANK;
    localparam int unsigned NUM_INDEX_REGS = 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  access_size;
        logic [7:0]  reg_code;
        logic        flag_set;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        mapped;
        logic        fetch_flush;
    } rsp_t;

    // Stored flags: C,N,V,H,Z,S in bits 0..5; byte form: C0 N1 V2 H4 Z6 S7
    function automatic logic [7:0] flags_pack(input logic [5:0] f);
        flags_pack = {f[5], f[4], 1'b0, f[3], 1'b0, f[2], f[1], f[0]};
    endfunction

    function automatic logic [5:0] flags_unpack(input logic [7:0] d);
        flags_unpack = {d[7], d[6], d[4], d[2], d[1], d[0]};
    endfunction

endpackage

// File: sv/bcrf_regs.sv
module bcrf_regs
    import bcrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  req_t req,
    output rsp_t rsp
);

    logic [31:0] bank_regs_reg [NUM_BANK_REGS];
    logic [31:0] index_regs_reg [NUM_INDEX_REGS];
    logic [31:0] pc_reg;
    logic [5:0]  flags_reg [2];
    logic [1:0]  bank_ptr_reg;
    logic [2:0]  imask_reg;

    logic        size_ok;
    logic        is_bank;
    logic        is_index;
    logic [1:0]  bank_sel;
    logic [1:0]  reg_sel;
    logic [3:0]  bank_idx;
    logic [31:0] cur_val;
    logic [31:0] rd_val;
    logic [31:0] wr_rep;
    logic [3:0]  byte_en;
    logic [31:0] wr_mask;
    logic [31:0] merged;
    logic [15:0] status_word;
    logic        reg_mapped;
    logic        wr_reg;

    assign size_ok = (req.access_size == SIZE_BYTE) || (req.access_size == SIZE_WORD)
                  || (req.access_size == SIZE_LONG);
    assign reg_sel  = req.reg_code[3:2];

    always_comb
    begin
        is_bank  = 1'b0;
        is_index = 1'b0;
        bank_sel = req.reg_code[5:4];
        priority if (req.reg_code[7:6] == 2'b00)
        begin
            is_bank = 1'b1;
        end
        else if (req.reg_code[7:4] == CODE_PREV_BANK)
        begin
            is_bank  = 1'b1;
            bank_sel = bank_ptr_reg - 2'd1;
        end
        else if (req.reg_code[7:4] == CODE_CUR_BANK)
        begin
            is_bank  = 1'b1;
            bank_sel = bank_ptr_reg;
        end
        else if (req.reg_code[7:4] == CODE_INDEX)
        begin
            is_index = 1'b1;
        end
        else
        begin
            // unmapped code range
            is_index = 1'b0;
        end
    end

    assign bank_idx   = {bank_sel, reg_sel};
    assign reg_mapped = size_ok && (is_bank || is_index);
    assign cur_val    = is_bank ? bank_regs_reg[bank_idx] : index_regs_reg[reg_sel];

    // Lane selection for narrow accesses
    always_comb
    begin
        rd_val  = cur_val;
        wr_rep  = req.write_data;
        byte_en = 4'b1111;
        unique case (req.access_size)
            SIZE_BYTE:
            begin
                rd_val  = {24'd0, cur_val[8*req.reg_code[1:0] +: 8]};
                wr_rep  = {4{req.write_data[7:0]}};
                byte_en = 4'b0001 << req.reg_code[1:0];
            end
            SIZE_WORD:
            begin
                rd_val  = {16'd0, cur_val[16*req.reg_code[1] +: 16]};
                wr_rep  = {2{req.write_data[15:0]}};
                byte_en = req.reg_code[1] ? 4'b1100 : 4'b0011;
            end
            default:
            begin
                rd_val  = cur_val;
                wr_rep  = req.write_data;
                byte_en = 4'b1111;
            end
        endcase
    end

    assign wr_mask = {{8{byte_en[3]}}, {8{byte_en[2]}}, {8{byte_en[1]}}, {8{byte_en[0]}}};
    assign merged  = (cur_val & ~wr_mask) | (wr_rep & wr_mask);

    assign status_word = {1'b1, imask_reg, 1'b1, 1'b0, bank_ptr_reg, flags_pack(flags_reg[0])};

    always_comb
    begin
        rsp = '0;
        unique case (req.kind)
            KIND_RD_REG:
            begin
                rsp.mapped    = reg_mapped;
                rsp.read_data = reg_mapped ? rd_val : 32'd0;
            end
            KIND_WR_REG:    rsp.mapped      = reg_mapped;
            KIND_RD_FLAGS:  rsp.read_data   = {24'd0, flags_pack(flags_reg[req.flag_set])};
            KIND_RD_STATUS: rsp.read_data   = {16'd0, status_word};
            KIND_RD_PC:     rsp.read_data   = pc_reg;
            KIND_WR_PC:     rsp.fetch_flush = 1'b1;
            default:        rsp = '0;
        endcase
    end

    assign wr_reg = en && (req.kind == KIND_WR_REG) && reg_mapped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BANK_REGS; i++)
            begin
                bank_regs_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_INDEX_REGS; i++)
            begin
                index_regs_reg[i] <= '0;
            end
            pc_reg       <= '0;
            flags_reg[0] <= '0;
            flags_reg[1] <= '0;
            bank_ptr_reg <= '0;
            imask_reg    <= '0;
        end
        else
        begin
            if (wr_reg && is_bank)
            begin
                bank_regs_reg[bank_idx] <= merged;
            end
            if (wr_reg && is_index)
            begin
                index_regs_reg[reg_sel] <= merged;
            end
            if (en && (req.kind == KIND_WR_FLAGS))
            begin
                flags_reg[req.flag_set] <= flags_unpack(req.write_data[7:0]);
            end
            if (en && (req.kind == KIND_WR_STATUS))
            begin
                flags_reg[0] <= flags_unpack(req.write_data[7:0]);
                bank_ptr_reg <= req.write_data[9:8];
                imask_reg    <= req.write_data[14:12];
            end
            if (en && (req.kind == KIND_WR_PC))
            begin
                pc_reg <= req.write_data;
            end
        end
    end

endmodule

// File: sv/banked_cpu_register_file.sv
// Banked CPU register file: four banks of four 32-bit registers, four index/stack
// registers, a program counter, two flag sets and the packed status word. Each
// input beat is one access (register byte/word/long read or write by 8-bit code,
// flag, status or PC read/write) and returns exactly one result beat. The block
// takes one beat per clock while the output is not stalled; a beat is held in the
// input register, is executed against the register state there, and its result is
// loaded into the output register as the beat leaves the input register, from which
// the result beat is offered. With both registers full and the output held off, the
// input is refused until the result beat is taken.
// State is updated as a beat moves from the input to the output register, so the
// following beat always sees the effect of the one before it. For register
// accesses, unmapped codes and access size 3 read as zero with mapped low, and
// their writes are dropped.
module banked_cpu_register_file
    import bcrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] access_size, [9:2] reg_code, [10] flag_set, [42:11] write_data,
    // [47:43] zero fill
    input  logic [47:0] s_tdata,
    // [2:0] kind
    input  logic [2:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_data
    output logic [31:0] m_tdata,
    // [0] mapped, [1] fetch_flush
    output logic [1:0]  m_tuser
);

    // Input register
    logic in_valid_reg;
    req_t in_req_reg;

    // Result register
    logic out_valid_reg;
    rsp_t out_rsp_reg;

    logic advance;
    logic s_beat;
    rsp_t rsp;

    // Execute whenever the result register is empty or being drained this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    bcrf_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .req   (in_req_reg),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_req_reg.kind        <= s_tuser;
            in_req_reg.access_size <= s_tdata[1:0];
            in_req_reg.reg_code    <= s_tdata[9:2];
            in_req_reg.flag_set    <= s_tdata[10];
            in_req_reg.write_data  <= s_tdata[42:11];
        end
        if (advance)
        begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rsp_reg.read_data;
    assign m_tuser  = {out_rsp_reg.fetch_flush, out_rsp_reg.mapped};

endmodule

// File: sv/bcrf_checker.sv
module bcrf_checker
    import bcrf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A result beat stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // A PC write never reports data or a mapped register
    a_flush_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata == 32'd0) && !m_tuser[0])
        else $error("flush beat carries data or mapped flag");

    // A beat accepted while no result is offered is followed by an offered result beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing two cycles after accept");

endmodule

bind banked_cpu_register_file bcrf_checker u_bcrf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
